// ----- rtl/page_table_walk_flags_core_macros.svh -----
// Assertion helpers for the page table walker checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef PAGE_TABLE_WALK_FLAGS_CORE_MACROS_SVH
`define PAGE_TABLE_WALK_FLAGS_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define PTWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define PTWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptwf_pkg.sv -----
package ptwf_pkg;

  // Item operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Walk levels
  localparam logic [1:0] LVL_4K  = 2'd0;
  localparam logic [1:0] LVL_2M  = 2'd1;
  localparam logic [1:0] LVL_1G  = 2'd2;
  localparam logic [1:0] LVL_TOP = 2'd3;

  // Entry bit positions and table geometry
  localparam int PRESENT_BIT = 0;
  localparam int HUGE_BIT    = 7;
  localparam int IDX_W       = 9;
  localparam int TABLE_WORDS = 512;
  localparam int FLAGS_W     = 12;
  localparam int FRAME_W     = 40;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_en;    // write zero at the clear counter, advance it
    logic wr_en;     // store the item's word
    logic lk_start;  // capture the lookup and read the top-level entry
    logic step;      // descend one level and read the next entry
    logic finish;    // load the result register
  } ptwf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // clear counter at the last word
    logic stop;      // the entry just read ends the walk
  } ptwf_stat_t;

endpackage

// ----- rtl/page_table_walk_flags_core.sv -----
// Channel   Handshake            Payload
// input     start & !busy        in_operation, in_word_index, in_word_value, in_virtual_address
// result    out_valid, 1 cycle   out_mapped, out_entry_flags, out_end_level, out_out_of_range
// config    cfg_we               cfg_root_table_addr
//
// A write item is stored at the accepting edge and leaves busy low.
// A lookup item issues the top-level read at the accepting edge and then examines one level
// at a time in the walk state, as each read depends on the entry before it through the
// single read port of the table memory, until the edge that registers its result.
// The result shows for the next cycle; a new item can be accepted at the edge that ends it.
// After reset the table memory is zeroed one word a cycle, all MEM_WORDS words, with busy high;
// configuration writes are taken throughout. The receiver cannot stall the result.
module page_table_walk_flags_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [11:0] in_word_index,
  input  logic [63:0] in_word_value,
  input  logic [47:0] in_virtual_address,
  // result items
  output logic        out_valid,
  output logic        out_mapped,
  output logic [11:0] out_entry_flags,
  output logic [1:0]  out_end_level,
  output logic        out_out_of_range,
  // configuration
  input  logic        cfg_we,
  input  logic [14:0] cfg_root_table_addr
);

  ptwf_pkg::ptwf_cmd_t  cmd;
  ptwf_pkg::ptwf_stat_t stat;

  // Sequence clear, idle and walk; decide from the datapath's stop status
  // when the walk ends.
  ptwf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Hold the table memory, the root register, the walk registers and the
  // result register. Each walk cycle checks the entry just read and issues
  // the read of the next one in the same cycle.
  ptwf_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_root_table_addr (cfg_root_table_addr),
    .in_word_index       (in_word_index),
    .in_word_value       (in_word_value),
    .in_virtual_address  (in_virtual_address),
    .out_valid           (out_valid),
    .out_mapped          (out_mapped),
    .out_entry_flags     (out_entry_flags),
    .out_end_level       (out_end_level),
    .out_out_of_range    (out_out_of_range)
  );

endmodule

// ----- rtl/ptwf_ctrl.sv -----
module ptwf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_operation,
  input  ptwf_pkg::ptwf_stat_t stat,
  output ptwf_pkg::ptwf_cmd_t  cmd,
  output logic                busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_operation == ptwf_pkg::OP_LOOKUP) begin
            cmd.lk_start = 1'b1;
            state_nxt    = S_WALK;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (stat.stop) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/ptwf_dp.sv -----
module ptwf_dp #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptwf_pkg::ptwf_cmd_t  cmd,
  output ptwf_pkg::ptwf_stat_t stat,
  input  logic                 cfg_we,
  input  logic [14:0]          cfg_root_table_addr,
  input  logic [11:0]          in_word_index,
  input  logic [63:0]          in_word_value,
  input  logic [47:0]          in_virtual_address,
  output logic                 out_valid,
  output logic                 out_mapped,
  output logic [11:0]          out_entry_flags,
  output logic [1:0]           out_end_level,
  output logic                 out_out_of_range
);

  localparam int AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int PW    = (AW > ptwf_pkg::IDX_W) ? AW - ptwf_pkg::IDX_W : 1;
  localparam int PAGES = MEM_WORDS / ptwf_pkg::TABLE_WORDS;

  logic [63:0] mem [MEM_WORDS];

  logic [14:0]   root_r;
  logic [AW-1:0] clr_cnt_r;
  logic [26:0]   va_lo_r;      // virtual address bits 38:12
  logic [1:0]    level_r;
  logic          root_oor_r;
  logic [63:0]   rdata_r;

  logic          out_valid_r;
  logic          out_mapped_r;
  logic [11:0]   out_flags_r;
  logic [1:0]    out_level_r;
  logic          out_oor_r;

  logic          root_oor;
  logic [PW-1:0] root_page;
  logic          present;
  logic          huge;
  logic          last_lvl;
  logic          next_oor;
  logic          mapped;
  logic          oor;
  logic [ptwf_pkg::IDX_W-1:0] next_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          wr_en;

  assign root_oor  = {29'd0, root_r[14:12]} >= 32'(PAGES);
  assign root_page = PW'(root_r[14:12]);

  assign present  = rdata_r[ptwf_pkg::PRESENT_BIT];
  assign huge     = rdata_r[ptwf_pkg::HUGE_BIT];
  assign last_lvl = (level_r == ptwf_pkg::LVL_4K);
  assign next_oor = rdata_r[51:12] >= ptwf_pkg::FRAME_W'(PAGES);

  assign mapped = !root_oor_r && present && (huge || last_lvl);
  assign oor    = root_oor_r || (present && !huge && !last_lvl && next_oor);

  assign stat.stop     = root_oor_r || !present || huge || last_lvl || next_oor;
  assign stat.clr_last = (clr_cnt_r == AW'(MEM_WORDS - 1));

  // Index field for the level below the current one
  always_comb begin
    unique case (level_r)
      ptwf_pkg::LVL_TOP: next_idx = va_lo_r[26:18];
      ptwf_pkg::LVL_1G:  next_idx = va_lo_r[17:9];
      default:           next_idx = va_lo_r[8:0];
    endcase
  end

  always_comb begin
    if (cmd.lk_start) begin
      rd_addr = AW'({root_page, in_virtual_address[47:39]});
    end else begin
      rd_addr = AW'({PW'(rdata_r[51:12]), next_idx});
    end
  end

  always_comb begin
    if (cmd.clr_en) begin
      wr_addr = clr_cnt_r;
      wr_data = '0;
      wr_en   = 1'b1;
    end else begin
      wr_addr = AW'(in_word_index);
      wr_data = in_word_value;
      wr_en   = cmd.wr_en && ({20'd0, in_word_index} < 32'(MEM_WORDS));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_r <= cfg_root_table_addr;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_start) begin
      va_lo_r    <= in_virtual_address[38:12];
      level_r    <= ptwf_pkg::LVL_TOP;
      root_oor_r <= root_oor;
    end else if (cmd.step) begin
      level_r    <= level_r - 2'd1;
      root_oor_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_mapped_r <= mapped;
      out_flags_r  <= mapped ? rdata_r[ptwf_pkg::FLAGS_W-1:0] : '0;
      out_level_r  <= level_r;
      out_oor_r    <= oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped       = out_mapped_r;
  assign out_entry_flags  = out_flags_r;
  assign out_end_level    = out_level_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ----- rtl/ptwf_chk.sv -----
`include "page_table_walk_flags_core_macros.svh"

module ptwf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_mapped,
  input logic [11:0] out_entry_flags,
  input logic        out_out_of_range
);

  // An accepted lookup sends the block into its walk state and raises busy
  `PTWF_ASSERT_NEXT(a_lookup_busy, start && !busy && in_operation == ptwf_pkg::OP_LOOKUP, busy, "lookup accepted but busy low next cycle")
  // A result follows a walk cycle
  `PTWF_ASSERT_NOW(a_result_after_walk, out_valid, $past(busy), "result without a preceding walk")
  // One result per lookup, never two in a row
  `PTWF_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "result strobe held for two cycles")
  // Unmapped results carry no flags
  `PTWF_ASSERT_NOW(a_flags_zero, out_valid && !out_mapped, out_entry_flags == 12'd0, "flags set on unmapped result")
  // An out-of-range walk is never mapped
  `PTWF_ASSERT_NOW(a_oor_unmapped, out_valid && out_out_of_range, !out_mapped, "out-of-range result marked mapped")

endmodule

bind page_table_walk_flags_core ptwf_chk u_ptwf_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_mapped       (out_mapped),
  .out_entry_flags  (out_entry_flags),
  .out_out_of_range (out_out_of_range)
);

// ----- tb/tb_page_table_walk_flags_core.sv -----
`timescale 1ns / 100ps

module tb_page_table_walk_flags_core;

  localparam int MEM_WORDS   = 4096;
  localparam int TABLE_PAGES = MEM_WORDS / ptwf_pkg::TABLE_WORDS;

  // How one level of a built walk is filled in
  typedef enum int {
    STEP_DESCEND,  // present, points at a table inside memory (or a leaf at the 4K level)
    STEP_HUGE,     // present with the huge bit set
    STEP_ABSENT,   // present bit clear
    STEP_FAR,      // present, next table beyond table memory
    STEP_LEAVE     // write nothing, walk whatever memory already holds
  } step_kind_t;

  // One expected walk outcome, field for field as the result ports carry it
  typedef struct packed {
    logic        mapped;
    logic [11:0] flags;
    logic [1:0]  level;
    logic        oor;
  } walk_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [11:0] in_word_index;
  logic [63:0] in_word_value;
  logic [47:0] in_virtual_address;
  logic        out_valid;
  logic        out_mapped;
  logic [11:0] out_entry_flags;
  logic [1:0]  out_end_level;
  logic        out_out_of_range;
  logic        cfg_we;
  logic [14:0] cfg_root_table_addr;

  // Shadow of the block's state: table memory and the root register
  logic [63:0]  table_shadow [MEM_WORDS] = '{default: '0};
  logic [14:0]  root_shadow = '0;
  walk_result_t pending_walks[$];

  int  failures     = 0;
  int  items_sent   = 0;
  int  walks_seen   = 0;
  int  walks_mapped = 0;
  int  walks_absent = 0;
  int  walks_far    = 0;
  bit  idle_off     = 0;

  page_table_walk_flags_core #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_word_index      (in_word_index),
    .in_word_value      (in_word_value),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_mapped         (out_mapped),
    .out_entry_flags    (out_entry_flags),
    .out_end_level      (out_end_level),
    .out_out_of_range   (out_out_of_range),
    .cfg_we             (cfg_we),
    .cfg_root_table_addr(cfg_root_table_addr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk the shadow tables for one lookup item, level by level from the root.
  function automatic walk_result_t walk_tables(input logic [47:0] va);
    walk_result_t res;
    logic [63:0]  entry;
    logic [39:0]  page;
    logic [8:0]   idx;
    int           lvl;
    res  = '0;
    page = 40'(root_shadow >> 12);
    if (page >= TABLE_PAGES) begin
      res.level = ptwf_pkg::LVL_TOP;
      res.oor   = 1'b1;
      return res;
    end
    for (lvl = 3; lvl >= 0; lvl--) begin
      idx       = va[12 + ptwf_pkg::IDX_W * lvl +: ptwf_pkg::IDX_W];
      entry     = table_shadow[int'(page) * ptwf_pkg::TABLE_WORDS + idx];
      res.level = 2'(lvl);
      if (!entry[ptwf_pkg::PRESENT_BIT])
        return res;
      // The huge bit means nothing at the 4K level: any present entry there is a leaf
      if (lvl == 0 || entry[ptwf_pkg::HUGE_BIT]) begin
        res.mapped = 1'b1;
        res.flags  = entry[ptwf_pkg::FLAGS_W-1:0];
        return res;
      end
      page = entry[12 +: ptwf_pkg::FRAME_W];
      if (page >= TABLE_PAGES) begin
        res.oor = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none at all while idle_off is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 50)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] slot(input int page, input logic [8:0] idx);
    return 12'(page * ptwf_pkg::TABLE_WORDS + idx);
  endfunction

  function automatic logic [63:0] pte(input logic [11:0] high, input logic [39:0] frame,
                                      input logic [11:0] flags);
    return {high, frame, flags};
  endfunction

  task automatic note_failure(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    failures++;
    if (failures <= 10)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Present one item at the falling edge, hold it until it is taken, then
  // update the shadow or queue the expected walk outcome.
  task automatic issue_item(input logic op, input logic [11:0] idx,
                            input logic [63:0] value, input logic [47:0] va);
    int gap;
    @(negedge clk);
    start              = 1'b1;
    in_operation       = op;
    in_word_index      = idx;
    in_word_value      = value;
    in_virtual_address = va;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    items_sent++;
    if (op == ptwf_pkg::OP_WRITE) begin
      if (idx < MEM_WORDS)
        table_shadow[idx] = value;
    end else begin
      pending_walks.push_back(walk_tables(va));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Junk goes on the fields that each operation ignores.
  task automatic store_word(input logic [11:0] idx, input logic [63:0] value);
    issue_item(ptwf_pkg::OP_WRITE, idx, value, 48'({$urandom, $urandom}));
  endtask

  task automatic walk_address(input logic [47:0] va);
    issue_item(ptwf_pkg::OP_LOOKUP, 12'($urandom), {$urandom, $urandom}, va);
  endtask

  // Drop start, let every pending lookup come back, then idle on further falling edges.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_walks.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_root(input logic [14:0] addr);
    settle();
    cfg_root_table_addr = addr;
    cfg_we              = 1'b1;
    @(negedge clk);
    cfg_we      = 1'b0;
    root_shadow = addr;
  endtask

  // Right after reset every table is empty, so every walk stops at the top.
  task automatic test_cleared_memory();
    set_root(15'h0000);
    walk_address(48'h0000_0000_0000);
    walk_address(48'hFFFF_FFFF_FFFF);
    walk_address(48'($urandom));
  endtask

  // Build one walk for the all-ones address under root page 7, a level at a
  // time, and look it up after each change.
  task automatic test_directed_walks();
    logic [47:0] top_va;
    top_va = 48'hFFFF_FFFF_FFFF;
    set_root(15'h7FFF);
    walk_address(top_va);                                        // absent at top
    store_word(slot(7, 9'h1FF), pte(12'hFFF, 40'd3, 12'h07F));
    walk_address(top_va);                                        // absent at 1G level
    store_word(slot(3, 9'h1FF), pte(12'h000, 40'd5, 12'h001));
    walk_address(top_va);                                        // absent at 2M level
    store_word(slot(5, 9'h1FF), pte(12'hABC, 40'd0, 12'hF7F));
    walk_address(top_va);                                        // absent at 4K level
    store_word(slot(0, 9'h1FF), 64'hFFFF_FFFF_FFFF_FFFF);
    walk_address(top_va);                                        // 4K leaf, huge bit ignored
    store_word(slot(5, 9'h1FF), pte(12'h800, 40'd6, 12'h081));
    walk_address(top_va);                                        // 2M page
    store_word(slot(3, 9'h1FF), pte(12'h000, 40'hFF_FFFF_FFFF, 12'hFFF));
    walk_address(top_va);                                        // 1G page, frame ignored
    store_word(slot(7, 9'h1FF), pte(12'h000, 40'd0, 12'h081));
    walk_address(top_va);                                        // huge at top level
    store_word(slot(7, 9'h1FF), pte(12'h000, 40'd8, 12'h001));
    walk_address(top_va);                                        // next table just past memory
    store_word(slot(7, 9'h1FF), pte(12'h000, 40'd3, 12'h001));
    store_word(slot(3, 9'h1FF), pte(12'hFFF, 40'hFF_FFFF_FFFF, 12'h001));
    walk_address(top_va);                                        // far table at 1G level
    store_word(slot(3, 9'h1FF), pte(12'h000, 40'd5, 12'h001));
    store_word(slot(5, 9'h1FF), pte(12'h000, 40'd8, 12'h07F));
    walk_address(top_va);                                        // far table at 2M level
    store_word(12'd0, 64'd0);
    walk_address(48'h0000_0000_0000);                            // zero address, empty slot
  endtask

  function automatic step_kind_t pick_step(input int lvl);
    int r;
    r = $urandom_range(0, 99);
    if (lvl == 0)
      return (r < 88) ? STEP_DESCEND : (r < 96) ? STEP_ABSENT : STEP_LEAVE;
    if (r < 70)
      return STEP_DESCEND;
    if (r < 80)
      return STEP_HUGE;
    if (r < 88)
      return STEP_ABSENT;
    if (r < 95)
      return STEP_FAR;
    return STEP_LEAVE;
  endfunction

  // Lay down the entries for one random address from the root down, stopping
  // early on a huge, absent or far entry or an unwritten level, then look the address up.
  task automatic build_and_walk();
    logic [47:0] va;
    logic [39:0] frame;
    logic [11:0] flags;
    int          page;
    int          lvl;
    bit          stop;
    step_kind_t  kind;
    idle_off = ($urandom_range(0, 6) == 0);
    va   = 48'({$urandom, $urandom});
    page = int'(root_shadow[14:12]);
    stop = 1'b0;
    for (lvl = 3; lvl >= 0 && !stop; lvl--) begin
      kind  = pick_step(lvl);
      flags = 12'($urandom);
      frame = 40'({$urandom, $urandom});
      case (kind)
        STEP_DESCEND: begin
          flags[ptwf_pkg::PRESENT_BIT] = 1'b1;
          if (lvl != 0)
            flags[ptwf_pkg::HUGE_BIT] = 1'b0;
          frame = 40'($urandom_range(0, TABLE_PAGES - 1));
        end
        STEP_HUGE: begin
          flags[ptwf_pkg::PRESENT_BIT] = 1'b1;
          flags[ptwf_pkg::HUGE_BIT]    = 1'b1;
        end
        STEP_ABSENT: flags[ptwf_pkg::PRESENT_BIT] = 1'b0;
        STEP_FAR: begin
          flags[ptwf_pkg::PRESENT_BIT] = 1'b1;
          flags[ptwf_pkg::HUGE_BIT]    = 1'b0;
          // Hit the first page past memory often, otherwise anything beyond
          if (frame < TABLE_PAGES || $urandom_range(0, 3) == 0)
            frame = 40'(TABLE_PAGES);
        end
        default: ;
      endcase
      if (kind != STEP_LEAVE)
        store_word(slot(page, va[12 + ptwf_pkg::IDX_W * lvl +: ptwf_pkg::IDX_W]),
                   pte(12'($urandom), frame, flags));
      if (kind == STEP_DESCEND && lvl != 0)
        page = int'(frame);
      else
        stop = 1'b1;
    end
    walk_address(va);
    // Same page, different offset: must give the same outcome
    if ($urandom_range(0, 1) == 1)
      walk_address({va[47:12], 12'($urandom)});
    if ($urandom_range(0, 4) == 0)
      walk_address(48'({$urandom, $urandom}));
    idle_off = 1'b0;
  endtask

  task automatic test_random_walks();
    logic [14:0] roots [6];
    roots[0] = 15'h0000;
    roots[1] = 15'h7FFF;
    for (int i = 2; i < 6; i++)
      roots[i] = 15'($urandom);
    foreach (roots[i]) begin
      set_root(roots[i]);
      repeat (36) build_and_walk();
    end
  endtask

  // Unstructured writes and lookups over whatever the tables now hold.
  task automatic test_random_noise();
    set_root(15'($urandom));
    repeat (240) begin
      if ($urandom_range(0, 1) == 1)
        store_word(12'($urandom), {$urandom, $urandom});
      else
        walk_address(48'({$urandom, $urandom}));
    end
  endtask

  // Compare every result with the oldest outstanding walk.
  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_walks.size() == 0) begin
        note_failure("result with no lookup outstanding", 64'd0,
                     64'({out_mapped, out_entry_flags, out_end_level, out_out_of_range}));
      end else begin
        want = pending_walks.pop_front();
        walks_seen++;
        if (want.mapped)
          walks_mapped++;
        else if (want.oor)
          walks_far++;
        else
          walks_absent++;
        if (out_mapped !== want.mapped)
          note_failure("mapped", 64'(want.mapped), 64'(out_mapped));
        if (out_entry_flags !== want.flags)
          note_failure("entry_flags", 64'(want.flags), 64'(out_entry_flags));
        if (out_end_level !== want.level)
          note_failure("end_level", 64'(want.level), 64'(out_end_level));
        if (out_out_of_range !== want.oor)
          note_failure("out_of_range", 64'(want.oor), 64'(out_out_of_range));
      end
    end
  end

  // Give up well past the slowest correct run, clearing pass included.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_operation        = ptwf_pkg::OP_WRITE;
    in_word_index       = '0;
    in_word_value       = '0;
    in_virtual_address  = '0;
    cfg_we              = 1'b0;
    cfg_root_table_addr = '0;
    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_cleared_memory();
    test_directed_walks();
    test_random_walks();
    test_random_noise();

    // Drain: wait for the last lookups, bounded, then idle a while
    @(negedge clk);
    start = 1'b0;
    for (int i = 0; i < 200 && pending_walks.size() != 0; i++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_walks.size() != 0) begin
      failures += pending_walks.size();
      $display("%0d lookups never produced a result", pending_walks.size());
    end

    $display("Sent %0d items over roots 0, 0x7FFF and random; checked %0d walks.",
             items_sent, walks_seen);
    $display("Walk outcomes: %0d mapped, %0d not present, %0d beyond table memory.",
             walks_mapped, walks_absent, walks_far);
    if (failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
